### rtl/swfm_pkg.sv
// shared types, constants and twiddle lookup for the sliding window fft magnitude block
`timescale 1ns / 1ps
package swfm_pkg;

  localparam int unsigned WINDOW_SIZE_DEF = 256;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned WORK_EXTRA      = 10;
  localparam int unsigned TW_BITS         = 17;
  localparam int unsigned TW_FRAC         = 15;
  localparam int unsigned MAG_BITS        = 24;
  localparam int unsigned IDX_BITS        = 6;
  localparam int unsigned E_BITS          = 7;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_RDA,
    S_RDB,
    S_SUM,
    S_MUL1,
    S_MUL2,
    S_WRB,
    S_MRD,
    S_MCAP,
    S_MSQR,
    S_MSQI,
    S_MRUN,
    S_OUT
  } state_e;

  // round(32768 * sin(q*pi/128)), q = 0..64
  localparam logic signed [TW_BITS-1:0] QUARTER_SINE [0:64] = '{
    17'sd0, 17'sd804, 17'sd1608, 17'sd2411, 17'sd3212, 17'sd4011, 17'sd4808, 17'sd5602,
    17'sd6393, 17'sd7180, 17'sd7962, 17'sd8740, 17'sd9512, 17'sd10279, 17'sd11039,
    17'sd11793, 17'sd12540, 17'sd13279, 17'sd14010, 17'sd14733, 17'sd15447, 17'sd16151,
    17'sd16846, 17'sd17531, 17'sd18205, 17'sd18868, 17'sd19520, 17'sd20160, 17'sd20788,
    17'sd21403, 17'sd22006, 17'sd22595, 17'sd23170, 17'sd23732, 17'sd24279, 17'sd24812,
    17'sd25330, 17'sd25833, 17'sd26320, 17'sd26791, 17'sd27246, 17'sd27684, 17'sd28106,
    17'sd28511, 17'sd28899, 17'sd29269, 17'sd29622, 17'sd29957, 17'sd30274, 17'sd30572,
    17'sd30853, 17'sd31114, 17'sd31357, 17'sd31581, 17'sd31786, 17'sd31972, 17'sd32138,
    17'sd32286, 17'sd32413, 17'sd32522, 17'sd32610, 17'sd32679, 17'sd32729, 17'sd32758,
    17'sd32768
  };

  function automatic logic signed [TW_BITS-1:0] tw_re(input logic [E_BITS-1:0] e);
    logic [E_BITS-1:0] idx;
    if (e <= 7'd64) begin
      idx = 7'd64 - e;
      return QUARTER_SINE[idx];
    end
    idx = e - 7'd64;
    return -QUARTER_SINE[idx];
  endfunction

  function automatic logic signed [TW_BITS-1:0] tw_im(input logic [E_BITS-1:0] e);
    logic [E_BITS:0] idx;
    if (e <= 7'd64) begin
      return -QUARTER_SINE[e];
    end
    idx = 8'd128 - {1'b0, e};
    return -QUARTER_SINE[idx[E_BITS-1:0]];
  endfunction

endpackage

### rtl/swfm_ram.sv
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
module swfm_ram #(
  parameter int unsigned WIDTH = 52,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/swfm_cell.sv
// one sample cell of the window shift chain
`timescale 1ns / 1ps
module swfm_cell #(
  parameter int unsigned WIDTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else if (en_i) begin
      val_q <= d_i;
    end
  end

  assign q_o = val_q;

endmodule

### rtl/swfm_sqrt.sv
// iterative floor square root, two radicand bits per cycle
`timescale 1ns / 1ps
module swfm_sqrt #(
  parameter int unsigned W = 26
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [2*W-1:0] value_i,
  output logic           done_o,
  output logic [W-1:0]   root_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [2*W-1:0] val_q;
  logic [W:0]     rem_q;
  logic [W-1:0]   root_q;
  logic [CW-1:0]  cnt_q;
  logic           busy_q, done_q;
  logic [W+2:0]   rem_n, trial;

  always_comb begin
    rem_n = {rem_q, val_q[2*W-1 -: 2]};
    trial = {1'b0, root_q, 2'b01};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= value_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      val_q <= {val_q[2*W-3:0], 2'b00};
      if (rem_n >= trial) begin
        rem_q  <= (W+1)'(rem_n - trial);
        root_q <= {root_q[W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_n[W:0];
        root_q <= {root_q[W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

### rtl/sliding_window_fft_magnitude.sv
// top level: window cell chain, in-place radix-2 dif fft over a work ram, magnitude readout
//
//  channel | signals                                    | dir
//  in      | in_valid_i, in_ready_o, sample_i           | sink
//  out     | out_valid_o, out_ready_i, bin_pair_index_o, | source
//          | even_bin_magnitude_o, odd_bin_magnitude_o, |
//          | last_of_window_o                           |
//
// a sample that completes no window only shifts into the chain; a window sample starts a run of
// N chain rotation steps into the work ram, then (N/2)*log2(N) butterflies, each going through
// read a, read b, sum, two multiply states and write b (one ram port shared by the butterfly
// unit), then each bin through the shared square root unit plus one output beat per pair; for
// N = 256 a window is processed per 128 samples.
// input is not taken while a window is processed; output stalls hold the sequencer.
// reset clears the window chain and sample count; the work ram needs no clearing.
`timescale 1ns / 1ps
module sliding_window_fft_magnitude #(
  parameter int unsigned WINDOW_SIZE = swfm_pkg::WINDOW_SIZE_DEF,
  parameter int unsigned SAMPLE_BITS = swfm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]    sample_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [swfm_pkg::IDX_BITS-1:0]    bin_pair_index_o,
  output logic [swfm_pkg::MAG_BITS-1:0]    even_bin_magnitude_o,
  output logic [swfm_pkg::MAG_BITS-1:0]    odd_bin_magnitude_o,
  output logic                             last_of_window_o
);

  localparam int unsigned N   = WINDOW_SIZE;
  localparam int unsigned AW  = $clog2(N);
  localparam int unsigned LHW = $clog2(AW);
  localparam int unsigned KW  = AW - 2;
  localparam int unsigned W   = SAMPLE_BITS + swfm_pkg::WORK_EXTRA;
  localparam int unsigned TB  = swfm_pkg::TW_BITS;
  localparam int unsigned PW  = W + TB;
  localparam int unsigned EB  = swfm_pkg::E_BITS;
  localparam int unsigned MB  = swfm_pkg::MAG_BITS;

  function automatic logic [AW-1:0] bit_rev(input logic [AW-1:0] v);
    logic [AW-1:0] r;
    for (int i = 0; i < AW; i++) begin
      r[i] = v[AW-1-i];
    end
    return r;
  endfunction

  function automatic logic signed [W-1:0] rnd_q15(input logic signed [PW:0] s);
    logic signed [PW:0] t;
    t = s + (PW+1)'(1 << (swfm_pkg::TW_FRAC - 1));
    t = t >>> swfm_pkg::TW_FRAC;
    return W'(t);
  endfunction

  swfm_pkg::state_e state_q, state_d;

  // window cell chain, cell 0 holds the oldest sample
  logic [SAMPLE_BITS-1:0] cell_q [N];
  logic [SAMPLE_BITS-1:0] cell_d [N];
  logic                   chain_en;
  logic                   in_acc;

  assign in_acc   = in_valid_i && in_ready_o;
  assign chain_en = in_acc || (state_q == swfm_pkg::S_LOAD);

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == N - 1) begin : g_last
      assign cell_d[i] = (state_q == swfm_pkg::S_LOAD) ? cell_q[0] : sample_i;
    end else begin : g_mid
      assign cell_d[i] = cell_q[i+1];
    end
    swfm_cell #(.WIDTH(SAMPLE_BITS)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (chain_en),
      .d_i    (cell_d[i]),
      .q_o    (cell_q[i])
    );
  end

  // control counters
  logic [AW-1:0]  seen_q;
  logic [AW-1:0]  cnt_q;
  logic [LHW-1:0] lh_q;
  logic [KW-1:0]  k_q;
  logic           odd_q;

  // work ram
  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [2*W-1:0]  ram_wdata, ram_rdata;

  swfm_ram #(.WIDTH(2 * W), .DEPTH(N)) u_work (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // butterfly addressing and twiddle exponent
  logic [AW-1:0]   bf_low, bf_a, bf_b, bf_h;
  logic [AW+EB:0]  e_wide;
  logic [EB-1:0]   bf_e;
  logic signed [TB-1:0] w_re, w_im;
  logic [AW-1:0]   bin_addr;

  always_comb begin
    bf_h   = AW'(1) << lh_q;
    bf_low = cnt_q & (bf_h - 1'b1);
    bf_a   = ((cnt_q >> lh_q) << (lh_q + 1'b1)) | bf_low;
    bf_b   = bf_a | bf_h;
    e_wide = (AW+EB+1)'(bf_low) << (3'd7 - 3'(lh_q));
    bf_e   = e_wide[EB-1:0];
    w_re   = swfm_pkg::tw_re(bf_e);
    w_im   = swfm_pkg::tw_im(bf_e);
    bin_addr = bit_rev(AW'({k_q, odd_q}));
  end

  // butterfly datapath
  logic signed [W-1:0]  a_re_q, a_im_q, sum_re_q, sum_im_q, dif_re_q, dif_im_q, res_re_q;
  logic signed [PW-1:0] pa_q, pb_q;
  logic signed [W-1:0]  rd_re, rd_im;
  logic signed [PW:0]   p_diff, p_sum;

  assign rd_re  = ram_rdata[2*W-1:W];
  assign rd_im  = ram_rdata[W-1:0];
  assign p_diff = $signed((PW+1)'(pa_q)) - $signed((PW+1)'(pb_q));
  assign p_sum  = $signed((PW+1)'(pa_q)) + $signed((PW+1)'(pb_q));

  // magnitude datapath
  logic signed [W-1:0] m_re_q, m_im_q;
  logic [2*W-1:0]      sq_q, sq_im, sq_tot;
  logic                sq_start, sq_done;
  logic [W-1:0]        sq_root;
  logic [W+MB-1:0]     root_wide;
  logic [MB-1:0]       mag_sat;

  assign sq_im     = (2*W)'(m_im_q * m_im_q);
  assign sq_tot    = sq_q + sq_im;
  assign sq_start  = (state_q == swfm_pkg::S_MSQI);
  assign root_wide = (W+MB)'(sq_root);
  assign mag_sat   = (root_wide > (W+MB)'({MB{1'b1}})) ? {MB{1'b1}} : root_wide[MB-1:0];

  swfm_sqrt #(.W(W)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .value_i (sq_tot),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  logic stage_end, last_pair;
  assign stage_end = (cnt_q == AW'(N / 2 - 1));
  assign last_pair = (k_q == KW'(N / 4 - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      swfm_pkg::S_IDLE: if (in_acc && seen_q == AW'(N - 1)) state_d = swfm_pkg::S_LOAD;
      swfm_pkg::S_LOAD: if (cnt_q == AW'(N - 1)) state_d = swfm_pkg::S_RDA;
      swfm_pkg::S_RDA:  state_d = swfm_pkg::S_RDB;
      swfm_pkg::S_RDB:  state_d = swfm_pkg::S_SUM;
      swfm_pkg::S_SUM:  state_d = swfm_pkg::S_MUL1;
      swfm_pkg::S_MUL1: state_d = swfm_pkg::S_MUL2;
      swfm_pkg::S_MUL2: state_d = swfm_pkg::S_WRB;
      swfm_pkg::S_WRB: begin
        if (stage_end && lh_q == '0) state_d = swfm_pkg::S_MRD;
        else state_d = swfm_pkg::S_RDA;
      end
      swfm_pkg::S_MRD:  state_d = swfm_pkg::S_MCAP;
      swfm_pkg::S_MCAP: state_d = swfm_pkg::S_MSQR;
      swfm_pkg::S_MSQR: state_d = swfm_pkg::S_MSQI;
      swfm_pkg::S_MSQI: state_d = swfm_pkg::S_MRUN;
      swfm_pkg::S_MRUN: begin
        if (sq_done) state_d = odd_q ? swfm_pkg::S_OUT : swfm_pkg::S_MRD;
      end
      swfm_pkg::S_OUT: begin
        if (out_ready_i) state_d = last_pair ? swfm_pkg::S_IDLE : swfm_pkg::S_MRD;
      end
      default: state_d = swfm_pkg::S_IDLE;
    endcase
  end

  // ram control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = bf_a;
    ram_raddr = bf_a;
    ram_wdata = {sum_re_q, sum_im_q};
    case (state_q)
      swfm_pkg::S_LOAD: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = {W'($signed(cell_q[0])), {W{1'b0}}};
      end
      swfm_pkg::S_RDB:  ram_raddr = bf_b;
      swfm_pkg::S_MUL1: ram_we = 1'b1;
      swfm_pkg::S_WRB: begin
        ram_we    = 1'b1;
        ram_waddr = bf_b;
        // unit twiddle passes the difference unchanged
        ram_wdata = (bf_e == '0) ? {dif_re_q, dif_im_q} : {res_re_q, rnd_q15(p_sum)};
      end
      swfm_pkg::S_MRD:  ram_raddr = bin_addr;
      default: ram_we = 1'b0;
    endcase
  end

  assign in_ready_o = (state_q == swfm_pkg::S_IDLE);

  logic          out_valid_q, last_q;
  logic [KW-1:0] idx_q;
  logic [MB-1:0] even_q, odd_mag_q, even_hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swfm_pkg::S_IDLE;
      seen_q      <= '0;
      cnt_q       <= '0;
      lh_q        <= '0;
      k_q         <= '0;
      odd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        swfm_pkg::S_IDLE: begin
          cnt_q <= '0;
          if (in_acc) begin
            seen_q <= (seen_q == AW'(N - 1)) ? AW'(N / 2) : seen_q + 1'b1;
          end
        end
        swfm_pkg::S_LOAD: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == AW'(N - 1)) begin
            cnt_q <= '0;
            lh_q  <= LHW'(AW - 1);
          end
        end
        swfm_pkg::S_WRB: begin
          cnt_q <= cnt_q + 1'b1;
          if (stage_end) begin
            cnt_q <= '0;
            lh_q  <= lh_q - 1'b1;
            k_q   <= '0;
            odd_q <= 1'b0;
          end
        end
        swfm_pkg::S_MRUN: begin
          if (sq_done) begin
            odd_q <= ~odd_q;
            if (odd_q) out_valid_q <= 1'b1;
          end
        end
        swfm_pkg::S_OUT: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            k_q         <= k_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      swfm_pkg::S_RDB: begin
        a_re_q <= rd_re;
        a_im_q <= rd_im;
      end
      swfm_pkg::S_SUM: begin
        sum_re_q <= a_re_q + rd_re;
        sum_im_q <= a_im_q + rd_im;
        dif_re_q <= a_re_q - rd_re;
        dif_im_q <= a_im_q - rd_im;
      end
      swfm_pkg::S_MUL1: begin
        pa_q <= dif_re_q * w_re;
        pb_q <= dif_im_q * w_im;
      end
      swfm_pkg::S_MUL2: begin
        res_re_q <= rnd_q15(p_diff);
        pa_q     <= dif_re_q * w_im;
        pb_q     <= dif_im_q * w_re;
      end
      swfm_pkg::S_MCAP: begin
        m_re_q <= rd_re;
        m_im_q <= rd_im;
      end
      swfm_pkg::S_MSQR: sq_q <= (2*W)'(m_re_q * m_re_q);
      swfm_pkg::S_MRUN: begin
        if (sq_done) begin
          if (odd_q) begin
            even_q    <= even_hold_q;
            odd_mag_q <= mag_sat;
            idx_q     <= k_q;
            last_q    <= last_pair;
          end else begin
            even_hold_q <= mag_sat;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o          = out_valid_q;
  assign bin_pair_index_o     = swfm_pkg::IDX_BITS'(idx_q);
  assign even_bin_magnitude_o = even_q;
  assign odd_bin_magnitude_o  = odd_mag_q;
  assign last_of_window_o     = last_q;

`ifndef SYNTHESIS
  a_no_input_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input ready while a beat is pending");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_of_window_o) |-> (idx_q == KW'(N / 4 - 1)))
    else $error("last beat with wrong pair index");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == swfm_pkg::S_IDLE) |-> !ram_we) else $error("work ram written while idle");

  a_window_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == swfm_pkg::S_LOAD && $past(state_q) == swfm_pkg::S_IDLE) |->
      (seen_q == AW'(N / 2))) else $error("window started at wrong sample count");
`endif

endmodule
